// ===== rtl/speed_jump_segmenter_defines.svh =====
// Assertion macros used by the segmenter controller.
`ifndef SPEED_JUMP_SEGMENTER_DEFINES_SVH
`define SPEED_JUMP_SEGMENTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SJS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("speed_jump_segmenter assertion failed");

// Next-cycle implication.
`define SJS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("speed_jump_segmenter assertion failed");

`endif

// ===== rtl/sjs_pkg.sv =====
// Shared widths, constants and controller/datapath command types.
package sjs_pkg;

   localparam int SPEED_W = 10;
   localparam int LAT_W   = 31;
   localparam int LON_W   = 32;
   localparam int SUM_W   = 26;
   localparam int CNT_W   = 16;
   localparam int AVG_W   = 18;
   localparam int STEP_W  = 5;

   localparam logic [SPEED_W-1:0] THRESH_RESET       = 10'd9;
   localparam logic [CNT_W-1:0]   MAX_SEGMENT_POINTS = 16'd65535;
   localparam logic [SUM_W-1:0]   SUM_MAX            = {SUM_W{1'b1}};
   localparam logic [STEP_W-1:0]  DIV_STEPS          = 5'd18;

   typedef struct packed {
      logic load;
      logic div_start;
      logic end_is_sample;
      logic update;
      logic push;
      logic push_last;
   } cmd_type;

   typedef struct packed {
      logic jump;
      logic last;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/sjs_ifaces.sv =====
// Valid/ready channel interfaces for samples and segment results.
interface sjs_req_if import sjs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [SPEED_W-1:0]       speed;
   logic signed [LAT_W-1:0]  latitude;
   logic signed [LON_W-1:0]  longitude;
   logic                     trip_end;

   modport source (output valid, speed, latitude, longitude, trip_end, input ready);
   modport sink   (input valid, speed, latitude, longitude, trip_end, output ready);
endinterface

interface sjs_rsp_if import sjs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [LAT_W-1:0]  start_lat;
   logic signed [LON_W-1:0]  start_lon;
   logic signed [LAT_W-1:0]  end_lat;
   logic signed [LON_W-1:0]  end_lon;
   logic [CNT_W-1:0]         points;
   logic [AVG_W-1:0]         avg_speed_q8;
   logic                     run_last;

   modport source (output valid, start_lat, start_lon, end_lat, end_lon, points,
                   avg_speed_q8, run_last, input ready);
   modport sink   (input valid, start_lat, start_lon, end_lat, end_lon, points,
                   avg_speed_q8, run_last, output ready);
endinterface

// ===== rtl/sjs_datapath.sv =====
// Segment state, jump detect, iterative averaging divider and result register.
module sjs_datapath import sjs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [SPEED_W-1:0]      csr_wdata,
   input  logic [SPEED_W-1:0]      in_speed,
   input  logic signed [LAT_W-1:0] in_lat,
   input  logic signed [LON_W-1:0] in_lon,
   input  logic                    in_last,
   input  cmd_type                 cmd,
   output status_type              status,
   sjs_rsp_if.source               rsp
);

   logic [SPEED_W-1:0] thresh_ff, thresh_in;

   logic [SPEED_W-1:0] smp_speed_ff;
   logic [LAT_W-1:0]   smp_lat_ff;
   logic [LON_W-1:0]   smp_lon_ff;
   logic               smp_last_ff;

   logic [SPEED_W-1:0] prev_speed_ff, prev_speed_in;
   logic [LAT_W-1:0]   prev_lat_ff, prev_lat_in;
   logic [LON_W-1:0]   prev_lon_ff, prev_lon_in;
   logic               have_prev_ff, have_prev_in;
   logic [LAT_W-1:0]   seg_lat_ff, seg_lat_in;
   logic [LON_W-1:0]   seg_lon_ff, seg_lon_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // divider and result snapshot
   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [AVG_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   dvs_ff;
   logic [LAT_W-1:0]   r_slat_ff, r_elat_ff;
   logic [LON_W-1:0]   r_slon_ff, r_elon_ff;

   logic               ov_ff, ov_in;

   logic [SPEED_W-1:0] diff;
   logic [SUM_W:0]     sum_add;
   logic [CNT_W:0]     trial;
   logic               out_free;

   assign diff = (smp_speed_ff > prev_speed_ff) ? smp_speed_ff - prev_speed_ff
                                                : prev_speed_ff - smp_speed_ff;
   assign sum_add  = {1'b0, sum_ff} + {{(SUM_W+1-SPEED_W){1'b0}}, smp_speed_ff};
   assign trial    = {rem_ff, quo_ff[AVG_W-1]};
   assign out_free = !ov_ff || rsp.ready;

   assign status.jump     = have_prev_ff && (diff > thresh_ff);
   assign status.last     = smp_last_ff;
   assign status.div_busy = busy_ff;
   assign status.out_free = out_free;

   assign thresh_in = csr_we ? csr_wdata : thresh_ff;

   always_comb begin
      prev_speed_in = prev_speed_ff;
      prev_lat_in   = prev_lat_ff;
      prev_lon_in   = prev_lon_ff;
      have_prev_in  = have_prev_ff;
      seg_lat_in    = seg_lat_ff;
      seg_lon_in    = seg_lon_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      if (cmd.update) begin
         if (!have_prev_ff || status.jump) begin
            seg_lat_in = smp_lat_ff;
            seg_lon_in = smp_lon_ff;
            sum_in     = {{(SUM_W-SPEED_W){1'b0}}, smp_speed_ff};
            cnt_in     = {{(CNT_W-1){1'b0}}, 1'b1};
         end else if (cnt_ff < MAX_SEGMENT_POINTS) begin
            cnt_in = cnt_ff + 1'b1;
            sum_in = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
         end
         prev_speed_in = smp_speed_ff;
         prev_lat_in   = smp_lat_ff;
         prev_lon_in   = smp_lon_ff;
         have_prev_in  = !smp_last_ff;
      end
   end

   // restoring divide of (sum << 8) by count, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (cmd.div_start) begin
         busy_in = 1'b1;
         step_in = DIV_STEPS;
         rem_in  = sum_ff[SUM_W-1:SUM_W-CNT_W];
         quo_in  = {sum_ff[SUM_W-CNT_W-1:0], 8'd0};
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[AVG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[AVG_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != {{(STEP_W-1){1'b0}}, 1'b1});
      end
   end

   always_comb begin
      ov_in = ov_ff;
      if (cmd.push) begin
         ov_in = 1'b1;
      end else if (rsp.ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= THRESH_RESET;
         prev_speed_ff <= '0;
         prev_lat_ff   <= '0;
         prev_lon_ff   <= '0;
         have_prev_ff  <= 1'b0;
         seg_lat_ff    <= '0;
         seg_lon_ff    <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         busy_ff       <= 1'b0;
         step_ff       <= '0;
         ov_ff         <= 1'b0;
      end else begin
         thresh_ff     <= thresh_in;
         prev_speed_ff <= prev_speed_in;
         prev_lat_ff   <= prev_lat_in;
         prev_lon_ff   <= prev_lon_in;
         have_prev_ff  <= have_prev_in;
         seg_lat_ff    <= seg_lat_in;
         seg_lon_ff    <= seg_lon_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         busy_ff       <= busy_in;
         step_ff       <= step_in;
         ov_ff         <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load) begin
         smp_speed_ff <= in_speed;
         smp_lat_ff   <= in_lat;
         smp_lon_ff   <= in_lon;
         smp_last_ff  <= in_last;
      end
      if (cmd.div_start) begin
         dvs_ff    <= cnt_ff;
         r_slat_ff <= seg_lat_ff;
         r_slon_ff <= seg_lon_ff;
         r_elat_ff <= cmd.end_is_sample ? smp_lat_ff : prev_lat_ff;
         r_elon_ff <= cmd.end_is_sample ? smp_lon_ff : prev_lon_ff;
      end
      if (cmd.push) begin
         rsp.start_lat    <= r_slat_ff;
         rsp.start_lon    <= r_slon_ff;
         rsp.end_lat      <= r_elat_ff;
         rsp.end_lon      <= r_elon_ff;
         rsp.points       <= dvs_ff;
         rsp.avg_speed_q8 <= (dvs_ff == '0) ? '0 : quo_ff;
         rsp.run_last     <= cmd.push_last;
      end
   end

   assign rsp.valid = ov_ff;

endmodule

// ===== rtl/sjs_ctrl.sv =====
// Sequencing state machine: accept, evaluate, divide and push results.
`include "speed_jump_segmenter_defines.svh"

module sjs_ctrl import sjs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_EVAL    = 7'b0000010,
      ST_DIV_A   = 7'b0000100,
      ST_PUSH_A  = 7'b0001000,
      ST_START_B = 7'b0010000,
      ST_DIV_B   = 7'b0100000,
      ST_PUSH_B  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.jump) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_A;
            end else begin
               cmd.update = 1'b1;
               state_in   = status.last ? ST_START_B : ST_IDLE;
            end
         end
         ST_DIV_A: begin
            if (!status.div_busy) state_in = ST_PUSH_A;
         end
         ST_PUSH_A: begin
            if (status.out_free) begin
               cmd.push      = 1'b1;
               cmd.push_last = !status.last;
               cmd.update    = 1'b1;
               state_in      = status.last ? ST_START_B : ST_IDLE;
            end
         end
         ST_START_B: begin
            cmd.div_start     = 1'b1;
            cmd.end_is_sample = 1'b1;
            state_in          = ST_DIV_B;
         end
         ST_DIV_B: begin
            if (!status.div_busy) state_in = ST_PUSH_B;
         end
         ST_PUSH_B: begin
            if (status.out_free) begin
               cmd.push      = 1'b1;
               cmd.push_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SJS_ASSERT_NOW(a_push_slot_free, cmd.push, status.out_free && !status.div_busy)
   `SJS_ASSERT_NOW(a_start_when_idle_div, cmd.div_start, !status.div_busy)
   `SJS_ASSERT_NEXT(a_accept_then_eval, req_valid && req_ready, state_ff == ST_EVAL)
   `SJS_ASSERT_NEXT(a_start_then_busy, cmd.div_start, status.div_busy)

endmodule

// ===== rtl/speed_jump_segmenter.sv =====
// Top level of the speed jump segmenter.
// Usage:
//   req_chan carries one telematics sample per item (speed, latitude,
//   longitude, trip_end). rsp_chan returns one item per closed segment with
//   start/end coordinates, point count and mean speed in Q8 (run_last marks
//   the final result caused by a sample). csr_we/csr_wdata set the jump
//   threshold; write it only while the block is idle.
//   Timing: one sample at a time. A sample that closes no segment is
//   accepted and evaluated. A sample that closes a segment by a speed jump
//   starts the divider, and that result is pushed before the next sample
//   enters; a segment closed by trip_end is divided and pushed after the
//   sample's own update. With both, the jump result comes first and the
//   trip_end result second. The 18-step divider makes one quotient bit a cycle.
//   Reset (synchronous, active high) clears the segment state, sets the
//   threshold to 9 and empties the result register.
//   If the receiver stalls, the result waits in the output register and the
//   block holds off new samples until its next result can be placed.
module speed_jump_segmenter import sjs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   sjs_req_if.sink            req_chan,
   sjs_rsp_if.source          rsp_chan,
   input  logic               csr_we,
   input  logic [SPEED_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   sjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sjs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_speed  (req_chan.speed),
      .in_lat    (req_chan.latitude),
      .in_lon    (req_chan.longitude),
      .in_last   (req_chan.trip_end),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp_chan)
   );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the speed jump segmenter, with a built-in segment predictor.
`timescale 1ns / 1ps

module testbench import sjs_pkg::*; ();

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic [LAT_W-1:0]   lat;
      logic [LON_W-1:0]   lon;
      logic               trip_end;
   } sample_type;

   typedef struct packed {
      logic [LAT_W-1:0] start_lat;
      logic [LON_W-1:0] start_lon;
      logic [LAT_W-1:0] end_lat;
      logic [LON_W-1:0] end_lon;
      logic [CNT_W-1:0] points;
      logic [AVG_W-1:0] avg_q8;
      logic             run_last;
   } segment_type;

   localparam int STALL_CYCLES = 400;
   localparam int SETTLE_CYCLES = 60;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [SPEED_W-1:0] csr_wdata;

   sjs_req_if req_if ();
   sjs_rsp_if rsp_if ();

   speed_jump_segmenter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // segment tracking state
   logic [SPEED_W-1:0] jump_limit;
   logic [SPEED_W-1:0] last_speed;
   logic [LAT_W-1:0]   last_lat;
   logic [LON_W-1:0]   last_lon;
   logic               trip_open;
   logic [LAT_W-1:0]   seg_first_lat;
   logic [LON_W-1:0]   seg_first_lon;
   logic [SUM_W-1:0]   seg_sum;
   logic [CNT_W-1:0]   seg_points;

   segment_type segments_due[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          stalls_ordered = 0;
   int          stalls_served = 0;
   int          stall_left = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic segment_type close_segment(input logic [LAT_W-1:0] elat,
                                                 input logic [LON_W-1:0] elon,
                                                 input logic final_one);
      logic [SUM_W+7:0] quot;
      segment_type      seg;
      quot = '0;
      if (seg_points != 0)
         quot = {seg_sum, 8'd0} / seg_points;
      seg.start_lat = seg_first_lat;
      seg.start_lon = seg_first_lon;
      seg.end_lat   = elat;
      seg.end_lon   = elon;
      seg.points    = seg_points;
      seg.avg_q8    = quot[AVG_W-1:0];
      seg.run_last  = final_one;
      return seg;
   endfunction

   function automatic void queue_segment(input segment_type seg);
      segments_due.insert(segments_due.size(), seg);
   endfunction

   function automatic void open_segment(input sample_type s);
      seg_first_lat = s.lat;
      seg_first_lon = s.lon;
      seg_sum       = SUM_W'(s.speed);
      seg_points    = {{(CNT_W-1){1'b0}}, 1'b1};
   endfunction

   function automatic void predict_segments(input sample_type s);
      logic [SPEED_W-1:0] diff;
      if (!trip_open) begin
         open_segment(s);
      end else begin
         diff = (s.speed > last_speed) ? s.speed - last_speed : last_speed - s.speed;
         if (diff > jump_limit) begin
            queue_segment(close_segment(last_lat, last_lon, !s.trip_end));
            open_segment(s);
         end else if (seg_points < MAX_SEGMENT_POINTS) begin
            seg_points = seg_points + 1'b1;
            if (SUM_MAX - seg_sum < SUM_W'(s.speed))
               seg_sum = SUM_MAX;
            else
               seg_sum = seg_sum + SUM_W'(s.speed);
         end
      end
      last_speed = s.speed;
      last_lat   = s.lat;
      last_lon   = s.lon;
      trip_open  = 1'b1;
      if (s.trip_end) begin
         queue_segment(close_segment(s.lat, s.lon, 1'b1));
         trip_open = 1'b0;
      end
   endfunction

   // receiver: random back-pressure plus ordered long hold-offs
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (stalls_ordered != stalls_served) begin
         rsp_if.ready  <= 1'b0;
         stall_left    <= STALL_CYCLES;
         stalls_served <= stalls_served + 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_result
      segment_type got;
      segment_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.start_lat = rsp_if.start_lat;
         got.start_lon = rsp_if.start_lon;
         got.end_lat   = rsp_if.end_lat;
         got.end_lon   = rsp_if.end_lon;
         got.points    = rsp_if.points;
         got.avg_q8    = rsp_if.avg_speed_q8;
         got.run_last  = rsp_if.run_last;
         if (segments_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected segment result, start %h/%h end %h/%h", $realtime,
                        got.start_lat, got.start_lon, got.end_lat, got.end_lon);
         end else begin
            want = segments_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: segment mismatch\n",
                            "  expected start %h/%h end %h/%h points %0d avg %0d last %b\n",
                            "  actual   start %h/%h end %h/%h points %0d avg %0d last %b"},
                           $realtime,
                           want.start_lat, want.start_lon, want.end_lat, want.end_lon,
                           want.points, want.avg_q8, want.run_last,
                           got.start_lat, got.start_lon, got.end_lat, got.end_lon,
                           got.points, got.avg_q8, got.run_last);
            end
         end
      end
   end

   // entered and left at a falling edge; valid stays high until the next call or idle wait
   task automatic send_sample(input sample_type s);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.speed     <= s.speed;
      req_if.latitude  <= s.lat;
      req_if.longitude <= s.lon;
      req_if.trip_end  <= s.trip_end;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      predict_segments(s);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (segments_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_threshold(input logic [SPEED_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we     <= 1'b0;
      jump_limit = value;
   endtask

   function automatic sample_type mk(input int spd, input logic [LAT_W-1:0] lat,
                                     input logic [LON_W-1:0] lon, input logic last);
      sample_type s;
      s.speed    = SPEED_W'(spd);
      s.lat      = lat;
      s.lon      = lon;
      s.trip_end = last;
      return s;
   endfunction

   function automatic logic [LAT_W-1:0] rand_lat();
      if ($urandom_range(9) == 0)
         return LAT_W'($urandom);
      return LAT_W'($urandom_range(32'd1800000000) - 32'd900000000);
   endfunction

   function automatic logic [LON_W-1:0] rand_lon();
      if ($urandom_range(9) == 0)
         return $urandom;
      return $urandom_range(32'd3600000000) - 32'd1800000000;
   endfunction

   task automatic test_directed_extremes();
      send_sample(mk(0, -31'sd900000000, 32'sd1800000000, 1'b1));
      send_sample(mk(1023, 31'sd900000000, -32'sd1800000000, 1'b1));
      send_sample(mk(1023, 31'h3FFFFFFF, 32'h7FFFFFFF, 1'b1));
      send_sample(mk(0, 31'h40000000, 32'h80000000, 1'b1));
      send_sample(mk(7, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1));
      // diff equal to the threshold stays in the segment, one above breaks it
      send_sample(mk(100, 31'd0, 32'd0, 1'b0));
      send_sample(mk(109, 31'd1, 32'd1, 1'b0));
      send_sample(mk(118, 31'd2, 32'd2, 1'b0));
      send_sample(mk(128, 31'd3, 32'd3, 1'b0));
      send_sample(mk(119, 31'd4, 32'd4, 1'b0));
      send_sample(mk(0, 31'd5, 32'd5, 1'b1));
      send_sample(mk(1023, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(0, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(1023, rand_lat(), rand_lon(), 1'b1));
      send_sample(mk(500, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(500, rand_lat(), rand_lon(), 1'b1));
      send_sample(mk(333, 31'h2AAAAAAA, 32'h55555555, 1'b0));
      send_sample(mk(340, 31'h55555555, 32'hAAAAAAAA, 1'b1));
   endtask

   task automatic test_threshold_extremes();
      set_threshold(10'd0);
      send_sample(mk(5, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(5, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(6, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(6, rand_lat(), rand_lon(), 1'b1));
      set_threshold(10'd1023);
      send_sample(mk(0, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(1023, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(0, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(1023, rand_lat(), rand_lon(), 1'b1));
      set_threshold(10'd1022);
      send_sample(mk(0, rand_lat(), rand_lon(), 1'b0));
      send_sample(mk(1023, rand_lat(), rand_lon(), 1'b1));
   endtask

   task automatic test_output_stall();
      set_threshold(10'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stalls_ordered++;
      for (int k = 0; k < 24; k++)
         send_sample(mk((k % 2) ? 600 + $urandom_range(400) : $urandom_range(400),
                        rand_lat(), rand_lon(), (k % 7) == 6));
   endtask

   task automatic run_random_trips(input int count);
      int         sent;
      int         trip_len;
      int         spd;
      int         span;
      sample_type s;
      sent = 0;
      while (sent < count) begin
         trip_len = $urandom_range(16, 1);
         spd = $urandom_range(1023);
         for (int k = 0; k < trip_len && sent < count; k++) begin
            span = 2 * int'(jump_limit) + 2;
            if ($urandom_range(19) == 0) begin
               spd = $urandom_range(1023);
            end else begin
               spd = spd + int'($urandom_range(2 * span)) - span;
               if (spd < 0)
                  spd = 0;
               if (spd > 1023)
                  spd = 1023;
            end
            // some trips lose their closing flag and run into the next one
            s = mk(spd, rand_lat(), rand_lon(),
                   (k == trip_len - 1) && ($urandom_range(9) != 0));
            send_sample(s);
            sent++;
         end
      end
   endtask

   task automatic test_random_trips();
      send_idle_pct = 37;
      recv_idle_pct = 60;
      set_threshold(SPEED_W'($urandom_range(20, 5)));
      run_random_trips(240);
      send_idle_pct = 60;
      recv_idle_pct = 37;
      set_threshold(SPEED_W'($urandom_range(4, 0)));
      run_random_trips(230);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_threshold(SPEED_W'($urandom_range(200, 20)));
      run_random_trips(230);
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.speed     = '0;
      req_if.latitude  = '0;
      req_if.longitude = '0;
      req_if.trip_end  = 1'b0;
      jump_limit       = THRESH_RESET;
      last_speed       = '0;
      last_lat         = '0;
      last_lon         = '0;
      trip_open        = 1'b0;
      seg_first_lat    = '0;
      seg_first_lon    = '0;
      seg_sum          = '0;
      seg_points       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_extremes();
      test_threshold_extremes();
      test_output_stall();
      test_random_trips();
      wait_idle();
      if (mismatches == 0 && segments_due.size() == 0)
         $display("** speed_jump_segmenter: PASSED **");
      else
         $display("** speed_jump_segmenter: FAILED **");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("** speed_jump_segmenter: FAILED **");
      $finish;
   end

endmodule

// ===== speed_jump_segmenter.f =====
+incdir+rtl
rtl/sjs_pkg.sv
rtl/sjs_ifaces.sv
rtl/sjs_datapath.sv
rtl/sjs_ctrl.sv
rtl/speed_jump_segmenter.sv
bench/testbench.sv
